// File: rtl/nfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nfr_pkg
// Shared codes and field widths for the nibble frame receiver.
// ---------------------------------------------------------------------------
package nfr_pkg;

  // Field widths of the two channels
  localparam int CMD_W     = 2;
  localparam int CHAN_W    = 1;
  localparam int CHAR_W    = 8;
  localparam int IDX_W     = 8;
  localparam int LEN_W     = 9;
  localparam int DATA_W    = 8;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_RECEIVE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

  // Status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Framing characters
  localparam logic [CHAR_W-1:0] CH_STX     = 8'h02;
  localparam logic [CHAR_W-1:0] CH_ETX     = 8'h03;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7a;
  localparam logic [3:0]        NIB_MASK   = 4'hf;

endpackage

`default_nettype wire

// File: rtl/nfr_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nfr_in_if / nfr_out_if
// Valid/ready channels for command items and result items.
// ---------------------------------------------------------------------------
interface nfr_in_if;
  import nfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [CHAN_W-1:0] channel;
  logic [CHAR_W-1:0] rx_char;
  logic [IDX_W-1:0]  read_index;

  modport source (output valid, command, channel, rx_char, read_index, input ready);
  modport sink   (input valid, command, channel, rx_char, read_index, output ready);
endinterface

interface nfr_out_if;
  import nfr_pkg::*;

  logic              valid;
  logic              ready;
  logic              status;
  logic              frame_ready;
  logic [LEN_W-1:0]  frame_length;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, status, frame_ready, frame_length, read_data, input ready);
  modport sink   (input valid, status, frame_ready, frame_length, read_data, output ready);
endinterface

`default_nettype wire

// File: rtl/nibble_frame_receiver.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nibble_frame_receiver
// Per-channel STX/ETX deframer with nibble-letter decoding, additive
// checksum check and a shared payload buffer memory.
// ---------------------------------------------------------------------------
//  Port       Direction  Transfer carries
//  in_chan    sink       command, channel, rx_char, read_index
//  out_chan   source     status, frame_ready, frame_length, read_data
//
//  One item per cycle sustained while out_chan is not stalled; each result
//  passes stage 1 (state update, memory read register), then the output register.
//  Per-channel state sits in flip-flops updated in the transfer cycle, so
//  items to the same channel follow back to back without interlock.
//  Reset (rst_n low, synchronous) clears all channel state and holds
//  in_chan.ready low; the payload memory is not cleared. A stalled output
//  holds both pipeline stages.
// ---------------------------------------------------------------------------
module nibble_frame_receiver #(
  parameter int CHANNELS     = 2,
  parameter int BUFFER_BYTES = 256
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  nfr_in_if.sink     in_chan,
  nfr_out_if.source  out_chan
);
  import nfr_pkg::*;

  localparam int CIW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNTW  = $clog2(BUFFER_BYTES + 1);
  localparam int OFFW  = $clog2(BUFFER_BYTES);
  localparam int DEPTH = CHANNELS * BUFFER_BYTES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMPW  = (CNTW > IDX_W) ? CNTW : IDX_W;

  // Per-channel control state
  logic [CNTW-1:0]   cnt_r [CHANNELS];
  logic [7:0]        sum_r [CHANNELS];
  logic [7:0]        cur_r [CHANNELS];
  logic [CHANNELS-1:0] fv_r;

  logic [CNTW-1:0]   cnt_nxt;
  logic [7:0]        sum_nxt;
  logic [7:0]        cur_nxt;
  logic              fv_nxt;

  // Payload memory
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] mem_q_r;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;

  // Pipeline stages
  logic              s1_valid_r;
  logic              s1_status_r;
  logic              s1_fv_r;
  logic [LEN_W-1:0]  s1_len_r;
  logic              s1_rd_r;
  logic              out_valid_r;
  logic              out_status_r;
  logic              out_fv_r;
  logic [LEN_W-1:0]  out_len_r;
  logic [DATA_W-1:0] out_data_r;

  logic              accept;
  logic              s1_adv;
  logic              in_range;
  logic [CIW-1:0]    cidx;
  logic [CNTW-1:0]   cnt;
  logic [7:0]        sum;
  logic [7:0]        cur;
  logic              fv;
  logic [7:0]        ch;
  logic              is_upper;
  logic              is_lower;
  logic              status;
  logic              rd_ok;

  // Handshake: stage 1 advances when the output register is free; hold off in reset
  assign s1_adv        = !out_valid_r || out_chan.ready;
  assign in_chan.ready = rst_n && (!s1_valid_r || s1_adv);
  assign accept        = in_chan.valid && in_chan.ready;

  // Select channel state
  assign in_range = (CIW'(in_chan.channel) < CIW'(CHANNELS - 1)) ||
                    (CIW'(in_chan.channel) == CIW'(CHANNELS - 1));
  assign cidx     = CIW'(in_chan.channel);
  assign cnt      = cnt_r[cidx];
  assign sum      = sum_r[cidx];
  assign cur      = cur_r[cidx];
  assign fv       = fv_r[cidx];
  assign ch       = in_chan.rx_char;
  assign is_upper = (ch >= CH_UPPER_A) && (ch < CH_UPPER_Z);
  assign is_lower = (ch >= CH_LOWER_A) && (ch < CH_LOWER_Z);

  // Decode the command and compute the channel's next state
  always_comb begin
    cnt_nxt = cnt;
    sum_nxt = sum;
    cur_nxt = cur;
    fv_nxt  = fv;
    status  = STATUS_ERR;
    rd_ok   = 1'b0;
    mem_we  = 1'b0;
    unique case (in_chan.command)
      CMD_RECEIVE: begin
        if (ch == CH_STX) begin
          cnt_nxt = '0;
          sum_nxt = '0;
          cur_nxt = '0;
          fv_nxt  = 1'b0;
        end else if (ch == CH_ETX) begin
          if (cnt != '0) begin
            if (cur == sum) begin
              cnt_nxt = cnt - CNTW'(1);
              fv_nxt  = 1'b1;
              status  = STATUS_OK;
            end else begin
              cnt_nxt = '0;
              sum_nxt = '0;
              cur_nxt = '0;
              fv_nxt  = 1'b0;
            end
          end
        end else if (cnt >= CNTW'(BUFFER_BYTES)) begin
          cnt_nxt = '0;
          sum_nxt = '0;
          cur_nxt = '0;
          fv_nxt  = 1'b0;
        end else if (is_upper) begin
          if (cnt != '0) begin
            sum_nxt = sum + cur + 8'(cnt);
          end
          cur_nxt = {4'(ch - CH_UPPER_A) & NIB_MASK, 4'h0};
        end else if (is_lower) begin
          cur_nxt = cur | {4'h0, 4'(ch - CH_LOWER_A) & NIB_MASK};
          cnt_nxt = cnt + CNTW'(1);
          mem_we  = 1'b1;
        end
      end
      CMD_READ: begin
        if (fv && (CMPW'(in_chan.read_index) < CMPW'(cnt))) begin
          rd_ok  = 1'b1;
          status = STATUS_OK;
        end
      end
      CMD_CLEAR: begin
        cnt_nxt = '0;
        sum_nxt = '0;
        cur_nxt = '0;
        fv_nxt  = 1'b0;
        status  = STATUS_OK;
      end
      default: begin
        status = STATUS_ERR;
      end
    endcase
  end

  // Memory addresses: channel base plus byte offset
  assign mem_waddr = AW'(cidx) * AW'(BUFFER_BYTES) + AW'(cnt[OFFW-1:0]);
  assign mem_raddr = AW'(cidx) * AW'(BUFFER_BYTES) + AW'(OFFW'(in_chan.read_index));
  assign mem_re    = accept && in_range && rd_ok;

  // Update channel state on each transfer to a channel in range
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cnt_r[i] <= '0;
        sum_r[i] <= '0;
        cur_r[i] <= '0;
      end
      fv_r <= '0;
    end else if (accept && in_range) begin
      cnt_r[cidx] <= cnt_nxt;
      sum_r[cidx] <= sum_nxt;
      cur_r[cidx] <= cur_nxt;
      fv_r[cidx]  <= fv_nxt;
    end
  end

  // Payload memory: write appended bytes, registered read
  always_ff @(posedge clk) begin
    if (accept && in_range && mem_we) begin
      mem[mem_waddr] <= cur_nxt;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  // Stage 1: hold result fields while the read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= in_range ? status : STATUS_ERR;
      s1_fv_r     <= in_range ? fv_nxt : 1'b0;
      s1_len_r    <= in_range ? LEN_W'(cnt_nxt) : '0;
      s1_rd_r     <= in_range && rd_ok;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_status_r <= s1_status_r;
      out_fv_r     <= s1_fv_r;
      out_len_r    <= s1_len_r;
      out_data_r   <= s1_rd_r ? mem_q_r : '0;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.frame_ready  = out_fv_r;
  assign out_chan.frame_length = out_len_r;
  assign out_chan.read_data    = out_data_r;

endmodule

`default_nettype wire

// File: verif/nibble_frame_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nibble_frame_checker
// Watches the command and result channels of the nibble frame receiver,
// keeps its own copy of every channel's deframer state and payload buffer,
// and compares each result transfer field by field with the prediction.
// ---------------------------------------------------------------------------
module nibble_frame_checker
  import nfr_pkg::*;
#(
  parameter int CHANNELS     = 2,
  parameter int BUFFER_BYTES = 256
) (
  input  logic clk,
  input  logic rst_n,
  nfr_in_if    in_mon,
  nfr_out_if   out_mon,
  output int   failures,
  output int   pending,
  output int   results_seen,
  output int   frames_passed,
  output int   overflow_clears,
  output int   good_reads
);

  typedef struct packed {
    logic              status;
    logic              frame_ready;
    logic [LEN_W-1:0]  frame_length;
    logic [DATA_W-1:0] read_data;
  } frame_result_t;

  // Per-channel deframer state
  logic [LEN_W-1:0]  byte_cnt  [CHANNELS];
  logic [7:0]        sum_acc   [CHANNELS];
  logic [7:0]        last_byte [CHANNELS];
  logic              frame_ok  [CHANNELS];
  logic [DATA_W-1:0] payload   [CHANNELS][BUFFER_BYTES];

  frame_result_t expected_results[$];

  int fail_cnt     = 0;
  int result_cnt   = 0;
  int frame_cnt    = 0;
  int overflow_cnt = 0;
  int read_cnt     = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] result %0d: %s", $time, result_cnt, what);
    fail_cnt++;
  endtask

  task automatic clear_channel_state(input int c);
    byte_cnt[c]  = '0;
    sum_acc[c]   = '0;
    last_byte[c] = '0;
    frame_ok[c]  = 1'b0;
  endtask

  // Apply one received character to a channel
  task automatic take_char(input int c, input logic [CHAR_W-1:0] ch, output logic st);
    logic [CHAR_W-1:0] offs;
    st = STATUS_ERR;
    if (ch == CH_STX) begin
      clear_channel_state(c);
    end else if (ch == CH_ETX) begin
      // checksum byte must equal the running sum; drop it on a match
      if (byte_cnt[c] != 0) begin
        if (last_byte[c] == sum_acc[c]) begin
          byte_cnt[c] = byte_cnt[c] - 1'b1;
          frame_ok[c] = 1'b1;
          st = STATUS_OK;
          frame_cnt++;
        end else begin
          clear_channel_state(c);
        end
      end
    end else if (byte_cnt[c] >= BUFFER_BYTES) begin
      clear_channel_state(c);
      overflow_cnt++;
    end else if (ch >= CH_UPPER_A && ch < CH_UPPER_Z) begin
      // high nibble; fold the previous byte and its position into the sum
      offs = ch - CH_UPPER_A;
      if (byte_cnt[c] != 0)
        sum_acc[c] = sum_acc[c] + last_byte[c] + byte_cnt[c][7:0];
      last_byte[c] = {offs[3:0] & NIB_MASK, 4'h0};
    end else if (ch >= CH_LOWER_A && ch < CH_LOWER_Z) begin
      // low nibble completes the byte and stores it
      offs = ch - CH_LOWER_A;
      last_byte[c] = last_byte[c] | {4'h0, offs[3:0] & NIB_MASK};
      payload[c][byte_cnt[c]] = last_byte[c];
      byte_cnt[c] = byte_cnt[c] + 1'b1;
    end
  endtask

  task automatic predict_result(input logic [CMD_W-1:0] cmd, input int c,
                                input logic [CHAR_W-1:0] ch, input logic [IDX_W-1:0] idx,
                                output frame_result_t r);
    r.status    = STATUS_ERR;
    r.read_data = '0;
    case (cmd)
      CMD_RECEIVE: begin
        take_char(c, ch, r.status);
      end
      CMD_READ: begin
        if (frame_ok[c] && idx < byte_cnt[c]) begin
          r.read_data = payload[c][idx];
          r.status    = STATUS_OK;
          read_cnt++;
        end
      end
      CMD_CLEAR: begin
        clear_channel_state(c);
        r.status = STATUS_OK;
      end
      default: begin
      end
    endcase
    r.frame_ready  = frame_ok[c];
    r.frame_length = byte_cnt[c];
  endtask

  // Compare result transfers, then predict from command transfers
  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) clear_channel_state(c);
      expected_results.delete();
    end else begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        got = '{out_mon.status, out_mon.frame_ready, out_mon.frame_length, out_mon.read_data};
        result_cnt++;
        if (expected_results.size() == 0) begin
          report_mismatch("result transfer with no command waiting");
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0b, want %0b", got.status, want.status));
          if (got.frame_ready !== want.frame_ready)
            report_mismatch($sformatf("frame_ready %0b, want %0b",
                                      got.frame_ready, want.frame_ready));
          if (got.frame_length !== want.frame_length)
            report_mismatch($sformatf("frame_length %0d, want %0d",
                                      got.frame_length, want.frame_length));
          if (got.read_data !== want.read_data)
            report_mismatch($sformatf("read_data %02h, want %02h",
                                      got.read_data, want.read_data));
        end
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        predict_result(in_mon.command, int'(in_mon.channel), in_mon.rx_char,
                       in_mon.read_index, want);
        expected_results.push_back(want);
      end
    end
    failures        <= fail_cnt;
    pending         <= expected_results.size();
    results_seen    <= result_cnt;
    frames_passed   <= frame_cnt;
    overflow_clears <= overflow_cnt;
    good_reads      <= read_cnt;
  end

endmodule

// File: verif/nibble_frame_receiver_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nibble_frame_receiver_test
// Drives command items into the nibble frame receiver: a short directed
// pass over the framing corner cases, a fill of one buffer to overflow,
// then random good, corrupt, cut-short and noisy frames with read-back.
// Both channel sides idle at random; the checker beside the block predicts
// and compares every result.
// ---------------------------------------------------------------------------
module nibble_frame_receiver_test;
  import nfr_pkg::*;

  localparam int CHANNELS        = 2;
  localparam int BUFFER_BYTES    = 256;
  localparam int ITEM_TARGET     = 1100;
  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 10;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int HOLD_OFF_AFTER  = 300;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic clk;
  logic rst_n;

  nfr_in_if  in_if ();
  nfr_out_if out_if ();

  int failures;
  int pending;
  int results_seen;
  int frames_passed;
  int overflow_clears;
  int good_reads;

  int items_sent = 0;
  bit gapless    = 1'b0;

  nibble_frame_receiver #(
    .CHANNELS     (CHANNELS),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  nibble_frame_checker #(
    .CHANNELS     (CHANNELS),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_if),
    .out_mon         (out_if),
    .failures        (failures),
    .pending         (pending),
    .results_seen    (results_seen),
    .frames_passed   (frames_passed),
    .overflow_clears (overflow_clears),
    .good_reads      (good_reads)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Mostly short frames, some longer
  function automatic int pick_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, 8);
    return $urandom_range(9, 40);
  endfunction

  // Character that the deframer skips
  function automatic logic [CHAR_W-1:0] ignored_char();
    logic [CHAR_W-1:0] v;
    case ($urandom_range(0, 2))
      0: v = CH_UPPER_Z;
      1: v = CH_LOWER_Z;
      default: begin
        do v = 8'($urandom);
        while ((v >= CH_UPPER_A && v <= CH_UPPER_Z) || (v >= CH_LOWER_A && v <= CH_LOWER_Z) ||
               v == CH_STX || v == CH_ETX);
      end
    endcase
    return v;
  endfunction

  // Offer one item and hold it until the transfer
  task automatic drive_item(input logic [CMD_W-1:0] cmd, input logic chan,
                            input logic [CHAR_W-1:0] ch, input logic [IDX_W-1:0] idx);
    int gap;
    gap = gapless ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.command    <= cmd;
    in_if.channel    <= chan;
    in_if.rx_char    <= ch;
    in_if.read_index <= idx;
    in_if.valid      <= 1'b1;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    items_sent++;
  endtask

  task automatic send_char(input logic chan, input logic [CHAR_W-1:0] ch);
    drive_item(CMD_RECEIVE, chan, ch, 8'($urandom));
  endtask

  task automatic read_at(input logic chan, input logic [IDX_W-1:0] idx);
    drive_item(CMD_READ, chan, 8'($urandom), idx);
  endtask

  // Encode a byte as two letters; small nibbles sometimes use the aliased letters
  task automatic send_byte(input logic chan, input logic [7:0] b);
    logic [CHAR_W-1:0] hi;
    logic [CHAR_W-1:0] lo;
    hi = CH_UPPER_A + b[7:4];
    lo = CH_LOWER_A + b[3:0];
    if (b[7:4] <= 4'd8 && $urandom_range(0, 3) == 0) hi = hi + 8'd16;
    if (b[3:0] <= 4'd8 && $urandom_range(0, 3) == 0) lo = lo + 8'd16;
    send_char(chan, hi);
    send_char(chan, lo);
  endtask

  // Stray item on a channel: a read or a skipped character
  task automatic side_item(input logic chan);
    if ($urandom_range(0, 1) == 0) read_at(chan, 8'($urandom));
    else send_char(chan, ignored_char());
  endtask

  // STX, payload, checksum byte, ETX; skipped characters and items to the
  // other channel fall between payload bytes
  task automatic send_frame(input logic chan, input int n, input bit corrupt);
    logic [7:0] b;
    logic [7:0] sum;
    sum = '0;
    send_char(chan, CH_STX);
    for (int i = 1; i <= n; i++) begin
      if ($urandom_range(0, 19) == 0) send_char(chan, ignored_char());
      if ($urandom_range(0, 9) == 0) side_item(!chan);
      b   = 8'($urandom);
      sum = sum + b + 8'(i);
      send_byte(chan, b);
    end
    if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
    send_byte(chan, sum);
    send_char(chan, CH_ETX);
  endtask

  // Read the head of the payload, one past its end and a random index
  task automatic read_back(input logic chan, input int n);
    for (int k = 0; k <= n && k <= 10; k++) read_at(chan, 8'(k));
    read_at(chan, 8'(n));
    read_at(chan, 8'($urandom));
  endtask

  // Fill a buffer to the top, read its ends, then overrun it
  task automatic fill_to_overflow(input logic chan);
    send_frame(chan, BUFFER_BYTES - 1, 1'b0);
    read_at(chan, 8'd0);
    read_at(chan, 8'(BUFFER_BYTES - 2));
    read_at(chan, 8'(BUFFER_BYTES - 1));
    send_char(chan, CH_LOWER_A + 8'($urandom_range(0, 15)));
    read_at(chan, 8'(BUFFER_BYTES - 1));
    send_char(chan, CH_UPPER_A + 8'($urandom_range(0, 15)));
    read_at(chan, 8'd0);
  endtask

  // Result side: random stalls, one long hold-off once traffic is going
  initial begin
    int  stall;
    int  run;
    bit  held_off;
    held_off = 1'b0;
    out_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held_off && results_seen >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        stall    = HOLD_OFF_CYCLES;
      end else begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
      repeat (run) @(posedge clk);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1))
        idle = 0;
      else
        idle++;
    end
    $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
             STALL_LIMIT, pending);
    $display("simulation failed");
    $finish;
  end

  // Stimulus
  initial begin
    logic chan;
    int   n;
    int   kind;
    int   extra;

    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.command    <= CMD_RECEIVE;
    in_if.channel    <= 1'b0;
    in_if.rx_char    <= '0;
    in_if.read_index <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // read before any frame, ETX on an empty buffer, unused command
    read_at(1'b0, 8'd0);
    send_char(1'b0, CH_ETX);
    drive_item(CMD_UNUSED, 1'b0, 8'($urandom), 8'($urandom));
    // one-byte frame 0xff, checksum 0x00
    send_char(1'b0, CH_STX);
    send_byte(1'b0, 8'hff);
    send_byte(1'b0, 8'h00);
    send_char(1'b0, CH_ETX);
    read_at(1'b0, 8'd0);
    read_at(1'b0, 8'd1);
    read_at(1'b0, 8'hff);
    // repeated ETX while the last byte still equals the sum, then on empty
    send_char(1'b0, CH_ETX);
    send_char(1'b0, CH_ETX);
    // wrong checksum on the other channel
    send_char(1'b1, CH_STX);
    send_byte(1'b1, 8'h12);
    send_byte(1'b1, 8'h34);
    send_char(1'b1, CH_ETX);
    drive_item(CMD_CLEAR, 1'b0, 8'($urandom), 8'($urandom));
    // skipped characters
    send_char(1'b1, CH_UPPER_Z);
    send_char(1'b1, CH_LOWER_Z);
    send_char(1'b1, 8'hff);
    send_char(1'b1, 8'h00);

    fill_to_overflow(1'($urandom));

    while (items_sent < ITEM_TARGET) begin
      chan    = 1'($urandom);
      n       = pick_len();
      gapless = ($urandom_range(0, 3) == 0);
      kind    = $urandom_range(0, 99);
      if (kind < 55) begin
        send_frame(chan, n, 1'b0);
        read_back(chan, n);
      end else if (kind < 65) begin
        send_frame(chan, n, 1'b1);
        read_at(chan, 8'($urandom_range(0, n)));
      end else if (kind < 73) begin
        // cut short: maybe a dangling high nibble, then STX or ETX
        send_char(chan, CH_STX);
        repeat (n) send_byte(chan, 8'($urandom));
        if ($urandom_range(0, 1) == 0) send_char(chan, CH_UPPER_A + 8'($urandom_range(0, 24)));
        send_char(chan, ($urandom_range(0, 1) == 0) ? CH_ETX : CH_STX);
        read_at(chan, 8'($urandom_range(0, n)));
      end else if (kind < 81) begin
        // append bytes after a ready frame, then another ETX
        send_frame(chan, n, 1'b0);
        extra = $urandom_range(1, 3);
        repeat (extra) send_byte(chan, 8'($urandom));
        read_at(chan, 8'(n));
        send_char(chan, CH_ETX);
        read_back(chan, n + extra);
      end else if (kind < 88) begin
        drive_item(CMD_CLEAR, chan, 8'($urandom), 8'($urandom));
        read_at(chan, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4))
          drive_item(CMD_W'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
      end
    end

    // drain
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d command transfers and %0d result transfers.",
             items_sent, results_seen);
    $display("Frames passed ETX: %0d, overflow clears: %0d, payload reads ok: %0d.",
             frames_passed, overflow_clears, good_reads);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", failures);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: nibble_frame_receiver.f
rtl/nfr_pkg.sv
rtl/nfr_if.sv
rtl/nibble_frame_receiver.sv
verif/nibble_frame_checker.sv
verif/nibble_frame_receiver_test.sv
